### src/uera_pkg.sv
// ----------------------------------------------------------------------------
// Echo ranger package
// Shared widths, reset values, codes and the types that join the controller
// and the datapath of the averaging ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uera_pkg;

  // Field and state widths.
  localparam int LIM_W      = 11;
  localparam int CNT_W      = 8;
  localparam int SUM_W      = 19;
  localparam int DIST_W     = 11;
  localparam int PT_W       = 4;
  localparam int CODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Pulse ticks per centimetre, and the width of the running remainder.
  localparam int CM_DIVISOR = 58;
  localparam int REM_W      = 6;

  // Default timing of one ping.
  localparam int PRE_LOW_TICKS_DEF   = 2;
  localparam int TRIG_HIGH_TICKS_DEF = 10;
  localparam int PULSE_BITS_DEF      = 16;

  // Register values after reset.
  localparam logic [LIM_W-1:0] LIM_MIN_RST    = 11'd2;
  localparam logic [LIM_W-1:0] LIM_MAX_RST    = 11'd400;
  localparam logic [CNT_W-1:0] PING_COUNT_RST = 8'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIM_MIN    = 2'd0,
    CFG_LIM_MAX    = 2'd1,
    CFG_PING_COUNT = 2'd2
  } cfg_idx_e;

  // Result codes.
  typedef enum logic [CODE_W-1:0] {
    RC_NONE    = 2'd0,
    RC_AVG     = 2'd1,
    RC_NOVALID = 2'd2
  } result_code_e;

  // Phase of the ping sequence.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PRE  = 3'd1,
    PH_TRIG = 3'd2,
    PH_WAIT = 3'd3,
    PH_MEAS = 3'd4
  } phase_e;

  // Controller states.
  typedef enum logic [2:0] {
    CS_IDLE   = 3'd0,
    CS_EXEC   = 3'd1,
    CS_DSTART = 3'd2,
    CS_DWAIT  = 3'd3,
    CS_PUSH   = 3'd4
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic push;
  } uera_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } uera_stat_t;

endpackage

### src/uera_ifs.sv
// ----------------------------------------------------------------------------
// Echo ranger channels
// Valid/ready channels for tick requests, results and register writes.
// ----------------------------------------------------------------------------

// One microsecond tick request.
interface uera_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source(output valid, start_req, echo_level, input ready);
  modport sink(input valid, start_req, echo_level, output ready);
endinterface

// One result per tick.
interface uera_out_if import uera_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              trig_out;
  logic              busy_res;
  logic [CODE_W-1:0] result_code;
  logic [DIST_W-1:0] distance_cm;

  modport source(output valid, trig_out, busy_res, result_code, distance_cm, input ready);
  modport sink(input valid, trig_out, busy_res, result_code, distance_cm, output ready);
endinterface

// Register write channel.
interface uera_cfg_if import uera_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### src/ultrasonic_echo_ranger_avg.sv
// ----------------------------------------------------------------------------
// Averaging ultrasonic echo ranger
// Drives the trigger, times echo pulses and averages a number of pings.
// ----------------------------------------------------------------------------
// Each request on in_i is one microsecond tick: a start request and the
// sampled echo level. Every request yields exactly one result on out_o:
// trigger level, busy flag, result code and averaged distance in cm.
// Registers are written through cfg_i (index 0 lim_min, 1 lim_max,
// 2 ping_count), which is always ready; write them only while no tick
// is in flight.
// A tick passes through capture, state update and hand-off. Its result is
// loaded in the output register at hand-off, and the next request can be
// accepted in the cycle after hand-off. The tick that ends the last ping with
// at least one accepted distance runs the average through a bit-serial
// divider, one quotient bit per cycle, between state update and
// hand-off. One tick is in work at a time. The output register lets a new
// request be accepted while a result waits. When the receiver stalls, the
// finished result waits in hand-off and no further request is taken until
// the output register frees.
// Reset clears the sequence to idle and loads the register defaults.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_avg import uera_pkg::*; #(
  parameter int PRE_LOW_TICKS   = PRE_LOW_TICKS_DEF,
  parameter int TRIG_HIGH_TICKS = TRIG_HIGH_TICKS_DEF,
  parameter int PULSE_BITS      = PULSE_BITS_DEF
) (
  input logic           clk_i,
  input logic           rst_ni,
  uera_cfg_if.sink      cfg_i,
  uera_in_if.sink       in_i,
  uera_out_if.source    out_o
);

  uera_cmd_t  cmd;
  uera_stat_t stat;

  // Register writes complete at once.
  assign cfg_i.ready = 1'b1;

  // Controller.
  uera_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath.
  uera_dp #(
    .PRE_LOW_TICKS   (PRE_LOW_TICKS),
    .TRIG_HIGH_TICKS (TRIG_HIGH_TICKS),
    .PULSE_BITS      (PULSE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .start_req_i   (in_i.start_req),
    .echo_level_i  (in_i.echo_level),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .trig_out_o    (out_o.trig_out),
    .busy_res_o    (out_o.busy_res),
    .result_code_o (out_o.result_code),
    .distance_cm_o (out_o.distance_cm)
  );

endmodule

### src/uera_div.sv
// ----------------------------------------------------------------------------
// Echo ranger divider
// Restoring divider, one quotient bit per cycle, for the distance average.
// ----------------------------------------------------------------------------
module uera_div import uera_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    shifted = {rem_q, quo_q[SUM_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### src/uera_dp.sv
// ----------------------------------------------------------------------------
// Echo ranger datapath
// Registers, ping sequence state, pulse measurement, accumulation, the
// average divider and the result register.
// ----------------------------------------------------------------------------
module uera_dp import uera_pkg::*; #(
  parameter int PRE_LOW_TICKS   = PRE_LOW_TICKS_DEF,
  parameter int TRIG_HIGH_TICKS = TRIG_HIGH_TICKS_DEF,
  parameter int PULSE_BITS      = PULSE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  uera_cmd_t             cmd_i,
  output uera_stat_t            stat_o,
  input  logic                  start_req_i,
  input  logic                  echo_level_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  trig_out_o,
  output logic                  busy_res_o,
  output logic [CODE_W-1:0]     result_code_o,
  output logic [DIST_W-1:0]     distance_cm_o
);

  // Distance in cm is below 2^PULSE_BITS / 58, so five bits fewer suffice.
  localparam int QUO_W = PULSE_BITS - 5;
  localparam int CMP_W = (QUO_W > LIM_W) ? QUO_W : LIM_W;

  // Configuration registers.
  logic [LIM_W-1:0] lim_min_q;
  logic [LIM_W-1:0] lim_max_q;
  logic [CNT_W-1:0] ping_count_q;

  // Captured tick request.
  logic in_start_q;
  logic in_echo_q;

  // Sequence state.
  phase_e                phase_q, nx_phase, cur_phase;
  logic [PT_W-1:0]       pt_q, nx_pt, cur_pt, pt_inc;
  logic                  echo_prev_q;
  logic [PULSE_BITS-1:0] pulse_q, nx_pulse;
  logic [REM_W-1:0]      rem_q, nx_rem;
  logic [QUO_W-1:0]      quo_q, nx_quo;
  logic [CNT_W-1:0]      pings_q, nx_pings;
  logic [CNT_W-1:0]      valid_q, nx_valid;
  logic [SUM_W-1:0]      sum_q, nx_sum;
  logic                  d_ok;
  logic                  t_trig;
  result_code_e          t_code;
  logic                  need_div;

  // Pending result and output register.
  logic              pend_trig_q;
  logic              pend_busy_q;
  result_code_e      pend_code_q;
  logic [DIST_W-1:0] pend_avg_q;
  logic              out_valid_q;
  logic              out_trig_q;
  logic              out_busy_q;
  result_code_e      out_code_q;
  logic [DIST_W-1:0] out_dist_q;

  logic             div_done;
  logic [SUM_W-1:0] div_quo;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_min_q    <= LIM_MIN_RST;
      lim_max_q    <= LIM_MAX_RST;
      ping_count_q <= PING_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LIM_MIN:    lim_min_q    <= cfg_data_i[LIM_W-1:0];
        CFG_LIM_MAX:    lim_max_q    <= cfg_data_i[LIM_W-1:0];
        CFG_PING_COUNT: ping_count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture of the accepted tick request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_start_q <= start_req_i;
      in_echo_q  <= echo_level_i;
    end
  end

  // Effect of one tick on the sequence state.
  always_comb begin
    nx_pulse  = pulse_q;
    nx_rem    = rem_q;
    nx_quo    = quo_q;
    nx_pings  = pings_q;
    nx_valid  = valid_q;
    nx_sum    = sum_q;
    cur_phase = phase_q;
    cur_pt    = pt_q;
    t_trig    = 1'b0;
    t_code    = RC_NONE;
    need_div  = 1'b0;
    d_ok      = 1'b0;

    // A start request only counts while idle.
    if (phase_q == PH_IDLE && in_start_q) begin
      nx_pings = '0;
      nx_valid = '0;
      nx_sum   = '0;
      nx_pulse = '0;
      nx_rem   = '0;
      nx_quo   = '0;
      if (ping_count_q == '0) begin
        t_code = RC_NOVALID;
      end else begin
        cur_phase = PH_PRE;
        cur_pt    = '0;
      end
    end

    nx_phase = cur_phase;
    nx_pt    = cur_pt;
    pt_inc   = cur_pt + 1'b1;

    unique case (cur_phase)
      PH_IDLE: ;
      PH_PRE: begin
        if (pt_inc >= PT_W'(PRE_LOW_TICKS)) begin
          nx_phase = PH_TRIG;
          nx_pt    = '0;
        end else begin
          nx_pt = pt_inc;
        end
      end
      PH_TRIG: begin
        t_trig = 1'b1;
        if (pt_inc >= PT_W'(TRIG_HIGH_TICKS)) begin
          nx_phase = PH_WAIT;
          nx_pt    = '0;
        end else begin
          nx_pt = pt_inc;
        end
      end
      PH_WAIT: begin
        if (in_echo_q && !echo_prev_q) begin
          nx_phase = PH_MEAS;
          nx_pulse = '0;
          nx_rem   = '0;
          nx_quo   = '0;
        end
      end
      PH_MEAS: begin
        // Saturating pulse count; the quotient by 58 follows it step by step.
        if (pulse_q != '1) begin
          nx_pulse = pulse_q + 1'b1;
          if (rem_q == REM_W'(CM_DIVISOR - 1)) begin
            nx_rem = '0;
            nx_quo = quo_q + 1'b1;
          end else begin
            nx_rem = rem_q + 1'b1;
          end
        end
        if (!in_echo_q) begin
          d_ok = (CMP_W'(nx_quo) >= CMP_W'(lim_min_q)) &&
                 (CMP_W'(nx_quo) <= CMP_W'(lim_max_q));
          if (d_ok) begin
            nx_sum   = sum_q + SUM_W'(nx_quo);
            nx_valid = valid_q + 1'b1;
          end
          nx_pings = pings_q + 1'b1;
          if (nx_pings >= ping_count_q) begin
            nx_phase = PH_IDLE;
            if (nx_valid == '0) begin
              t_code = RC_NOVALID;
            end else begin
              t_code   = RC_AVG;
              need_div = 1'b1;
            end
          end else begin
            nx_phase = PH_PRE;
            nx_pt    = '0;
          end
        end
      end
      default: nx_phase = PH_IDLE;
    endcase
  end

  // Sequence state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pt_q        <= '0;
      echo_prev_q <= 1'b0;
      pulse_q     <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      pings_q     <= '0;
      valid_q     <= '0;
      sum_q       <= '0;
    end else if (cmd_i.exec) begin
      phase_q     <= nx_phase;
      pt_q        <= nx_pt;
      echo_prev_q <= in_echo_q;
      pulse_q     <= nx_pulse;
      rem_q       <= nx_rem;
      quo_q       <= nx_quo;
      pings_q     <= nx_pings;
      valid_q     <= nx_valid;
      sum_q       <= nx_sum;
    end
  end

  // Average of the accepted distances.
  uera_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (valid_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Pending result of the current tick.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      pend_trig_q <= t_trig;
      pend_busy_q <= (nx_phase != PH_IDLE);
      pend_code_q <= t_code;
      pend_avg_q  <= '0;
    end else if (div_done) begin
      pend_avg_q <= div_quo[DIST_W-1:0];
    end
  end

  // Output register; loads a new result when empty or as the old one leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_trig_q <= pend_trig_q;
      out_busy_q <= pend_busy_q;
      out_code_q <= pend_code_q;
      out_dist_q <= pend_avg_q;
    end
  end

  assign stat_o.need_div = need_div;
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign trig_out_o    = out_trig_q;
  assign busy_res_o    = out_busy_q;
  assign result_code_o = out_code_q;
  assign distance_cm_o = out_dist_q;

endmodule

### src/uera_ctrl.sv
// ----------------------------------------------------------------------------
// Echo ranger controller
// Sequences capture, state update, averaging and result hand-off per tick.
// ----------------------------------------------------------------------------
module uera_ctrl import uera_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  uera_stat_t stat_i,
  output uera_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.need_div ? CS_DSTART : CS_PUSH;
      end
      CS_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = CS_DWAIT;
      end
      CS_DWAIT: begin
        if (stat_i.div_done) begin
          state_d = CS_PUSH;
        end
      end
      CS_PUSH: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

endmodule

### tb/uera_ranger_checker.sv
// ----------------------------------------------------------------------------
// Echo ranger checker
// Watches the tick, result and register channels, predicts the outcome of
// every accepted tick request, and compares each accepted result with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module uera_ranger_checker import uera_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  uera_in_if   tick_mon,
  uera_out_if  res_mon,
  uera_cfg_if  cfg_mon,
  output int   errors_o,
  output int   pending_o,
  output logic ranging_o
);

  typedef struct packed {
    logic              trig;
    logic              busy;
    result_code_e      code;
    logic [DIST_W-1:0] dist_cm;
  } tick_result_t;

  // Register copies.
  logic [LIM_W-1:0] min_cm;
  logic [LIM_W-1:0] max_cm;
  logic [CNT_W-1:0] pings_per_req;

  // Sequence state of the ranger.
  phase_e                    seq_phase;
  logic [PT_W-1:0]           tick_in_phase;
  logic                      echo_last;
  logic [PULSE_BITS_DEF-1:0] echo_width;
  logic [CNT_W-1:0]          pings_taken;
  logic [CNT_W-1:0]          pings_kept;
  logic [SUM_W-1:0]          cm_total;

  tick_result_t expected_q[$];
  tick_result_t head_res;
  int           mismatches = 0;

  assign errors_o = mismatches;

  // Advances the ranger by one microsecond tick and returns what it shows.
  function automatic tick_result_t range_tick(input logic start, input logic echo);
    tick_result_t      r;
    logic [DIST_W-1:0] cm;
    r      = '0;
    r.code = RC_NONE;
    if (seq_phase == PH_IDLE && start) begin
      pings_taken = '0;
      pings_kept  = '0;
      cm_total    = '0;
      echo_width  = '0;
      if (pings_per_req == '0) begin
        r.code = RC_NOVALID;
      end else begin
        seq_phase     = PH_PRE;
        tick_in_phase = '0;
      end
    end
    case (seq_phase)
      PH_IDLE: ;
      PH_PRE: begin
        tick_in_phase = tick_in_phase + 1'b1;
        if (tick_in_phase >= PRE_LOW_TICKS_DEF) begin
          seq_phase     = PH_TRIG;
          tick_in_phase = '0;
        end
      end
      PH_TRIG: begin
        r.trig        = 1'b1;
        tick_in_phase = tick_in_phase + 1'b1;
        if (tick_in_phase >= TRIG_HIGH_TICKS_DEF) begin
          seq_phase     = PH_WAIT;
          tick_in_phase = '0;
        end
      end
      PH_WAIT: begin
        // Only a fresh rising edge starts the count.
        if (echo && !echo_last) begin
          seq_phase  = PH_MEAS;
          echo_width = '0;
        end
      end
      PH_MEAS: begin
        if (echo_width != '1) begin
          echo_width = echo_width + 1'b1;
        end
        if (!echo) begin
          cm = DIST_W'(echo_width / CM_DIVISOR);
          if (cm >= min_cm && cm <= max_cm) begin
            cm_total   = cm_total + cm;
            pings_kept = pings_kept + 1'b1;
          end
          pings_taken = pings_taken + 1'b1;
          if (pings_taken >= pings_per_req) begin
            seq_phase = PH_IDLE;
            if (pings_kept == '0) begin
              r.code = RC_NOVALID;
            end else begin
              r.code    = RC_AVG;
              r.dist_cm = DIST_W'(cm_total / pings_kept);
            end
          end else begin
            seq_phase     = PH_PRE;
            tick_in_phase = '0;
          end
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
    echo_last = echo;
    r.busy    = (seq_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Results are checked before new requests are predicted, so a result can
  // never be matched against the request accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cm        = LIM_MIN_RST;
      max_cm        = LIM_MAX_RST;
      pings_per_req = PING_COUNT_RST;
      seq_phase     = PH_IDLE;
      tick_in_phase = '0;
      echo_last     = 1'b0;
      echo_width    = '0;
      pings_taken   = '0;
      pings_kept    = '0;
      cm_total      = '0;
      expected_q.delete();
      pending_o <= 0;
      ranging_o <= 1'b0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request waiting, expected none, got code %0d cm %0d",
                   $time, res_mon.result_code, res_mon.distance_cm);
        end else begin
          head_res = expected_q.pop_front();
          check_field("trig_out", head_res.trig, res_mon.trig_out);
          check_field("busy_res", head_res.busy, res_mon.busy_res);
          check_field("result_code", head_res.code, res_mon.result_code);
          check_field("distance_cm", head_res.dist_cm, res_mon.distance_cm);
        end
      end

      // Register writes must land only with no tick in flight; not enforced.
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_LIM_MIN:    min_cm = cfg_mon.data;
          CFG_LIM_MAX:    max_cm = cfg_mon.data;
          CFG_PING_COUNT: pings_per_req = cfg_mon.data[CNT_W-1:0];
          default: ;
        endcase
      end

      if (tick_mon.valid && tick_mon.ready) begin
        expected_q.push_back(range_tick(tick_mon.start_req, tick_mon.echo_level));
      end

      pending_o <= expected_q.size();
      ranging_o <= (seq_phase != PH_IDLE);
    end
  end

endmodule

### tb/ultrasonic_echo_ranger_avg_tb.sv
// ----------------------------------------------------------------------------
// Echo ranger testbench
// Feeds microsecond tick requests to the averaging echo ranger: directed
// pings at the limits, a zero ping count, crossed limits and several short
// pings in a row, then random well-formed measurements mixed with noise.
// Sender gaps and receiver stalls vary, apart from the run of short pings;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ultrasonic_echo_ranger_avg_tb;
  import uera_pkg::*;

  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_TICKS = 500;
  localparam int MIN_AVERAGES = 3;
  localparam int SETUP_TICKS  = PRE_LOW_TICKS_DEF + TRIG_HIGH_TICKS_DEF;

  // Index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // How the echo line behaves around one ping.
  typedef enum {ECHO_CLEAN, ECHO_NOISY, ECHO_HELD} echo_style_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  uera_in_if  tick_ch ();
  uera_out_if res_ch ();
  uera_cfg_if cfg_ch ();

  int          errors;
  int          pending;
  logic        ranging;
  logic        quiet = 1'b0;
  int          burst_left = 0;
  int          live_ticks = 0;
  int          measures = 0;
  int          pulses[$];
  logic [15:0] ready_pat = '1;
  logic [3:0]  stall_step = '0;
  int unsigned cycles = 0;

  ultrasonic_echo_ranger_avg dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (tick_ch),
    .out_o  (res_ch)
  );

  uera_ranger_checker echo_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_mon  (tick_ch),
    .res_mon   (res_ch),
    .cfg_mon   (cfg_ch),
    .errors_o  (errors),
    .pending_o (pending),
    .ranging_o (ranging)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The receiver stalls on a random ready pattern that is redrawn each round.
  always @(posedge clk_i) begin
    if (stall_step == 4'd0) begin
      case ($urandom_range(3))
        0:       ready_pat = '1;
        1:       ready_pat = 16'($urandom);
        2:       ready_pat = 16'($urandom | $urandom);
        default: ready_pat = 16'($urandom | ($urandom & $urandom));
      endcase
    end
    res_ch.ready <= quiet | ready_pat[stall_step];
    stall_step   <= stall_step + 1'b1;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Presents one tick request, in bursts with random gaps between them.
  task automatic send_tick(input logic start, input logic echo, input logic counted);
    int gap;
    if (!quiet && burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap        = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    if (counted) begin
      live_ticks++;
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.start_req  <= start;
    tick_ch.echo_level <= echo;
    do @(posedge clk_i); while (!tick_ch.ready);
  endtask

  // Stops sending and waits for every predicted result.
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Keeps the register channel valid across consecutive writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic set_ranging(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                             input logic [CFG_DATA_W-1:0] count, input logic spare);
    write_reg(CFG_LIM_MIN, lo);
    write_reg(CFG_LIM_MAX, hi);
    write_reg(CFG_PING_COUNT, count);
    if (spare) begin
      write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Toggles the echo until the current sequence has ended, then drains.
  task automatic finish_sequence();
    logic lvl;
    lvl = 1'b0;
    drain_results();
    while (ranging) begin
      lvl = ~lvl;
      send_tick(1'b0, lvl, 1'b1);
    end
    drain_results();
  endtask

  function automatic logic stray_start(input echo_style_e style);
    return (style != ECHO_CLEAN) && ($urandom_range(7) == 0);
  endfunction

  // One ping: trigger ticks, a short wait, then an echo pulse of len ticks.
  task automatic run_ping(input logic first, input int len, input echo_style_e style);
    int   setup_n;
    int   wait_n;
    logic lvl;
    setup_n = first ? SETUP_TICKS - 1 : SETUP_TICKS;
    lvl     = 1'b0;
    repeat (setup_n) begin
      lvl = (style == ECHO_HELD) || (style == ECHO_NOISY && $urandom_range(1) == 1);
      send_tick(stray_start(style), lvl, 1'b1);
    end
    // An echo still high after the trigger must not start the count.
    if (style == ECHO_HELD) begin
      send_tick(1'b0, 1'b1, 1'b1);
    end
    wait_n = $urandom_range(3, lvl ? 1 : 0);
    repeat (wait_n) send_tick(stray_start(style), 1'b0, 1'b1);
    send_tick(stray_start(style), 1'b1, 1'b1);
    repeat (len - 1) send_tick(stray_start(style), 1'b1, 1'b1);
    send_tick(stray_start(style), 1'b0, 1'b1);
  endtask

  // A start request followed by one ping per queued pulse length.
  task automatic run_measurement(input echo_style_e style);
    send_tick(1'b1, style == ECHO_NOISY ? 1'($urandom_range(1)) : 1'b0, 1'b1);
    for (int i = 0; i < pulses.size(); i++) begin
      run_ping(i == 0, pulses[i], style);
    end
    pulses.delete();
    measures++;
  endtask

  initial begin
    int               cur_pings;
    logic [LIM_W-1:0] lo;
    logic [LIM_W-1:0] hi;
    echo_style_e      style;

    rst_ni             = 1'b0;
    tick_ch.valid      = 1'b0;
    tick_ch.start_req  = 1'b0;
    tick_ch.echo_level = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_LIM_MIN;
    cfg_ch.data        = '0;
    res_ch.ready       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset limits: a pulse at the lower limit counts, one tick short does not.
    send_tick(1'b0, 1'b1, 1'b0);
    pulses.push_back(116);
    run_measurement(ECHO_CLEAN);
    pulses.push_back(115);
    run_measurement(ECHO_CLEAN);
    drain_results();

    // A ping count of zero answers at once; upper data bits are dropped.
    set_ranging(11'd0, 11'd0, 11'h700, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    drain_results();

    // Zero-width window with an echo held over the trigger and stray starts.
    set_ranging(11'd0, 11'd0, 11'd3, 1'b0);
    pulses.push_back(1);
    pulses.push_back(57);
    pulses.push_back(58);
    run_measurement(ECHO_HELD);
    drain_results();

    // Crossed limits accept nothing, even distances below the upper limit.
    set_ranging(11'h7FF, 11'd4, 11'd2, 1'b0);
    pulses.push_back(174);
    pulses.push_back(58);
    run_measurement(ECHO_NOISY);
    drain_results();

    // Several short pings around the first centimetre step; no idling here.
    quiet <= 1'b1;
    set_ranging(11'd1, 11'h7FF, 11'd4, 1'b0);
    repeat (4) pulses.push_back(58 * $urandom_range(1) + $urandom_range(3, 1));
    run_measurement(ECHO_NOISY);
    drain_results();
    quiet <= 1'b0;

    // Random settings, each with a few measurements and some noise.
    live_ticks = 0;
    measures   = 0;
    while (live_ticks < RANDOM_TICKS || measures < MIN_AVERAGES) begin
      finish_sequence();
      cur_pings = ($urandom_range(7) == 0) ? $urandom_range(5, 3) : $urandom_range(2, 1);
      lo        = ($urandom_range(9) == 0) ? 11'd0 : LIM_W'($urandom_range(4));
      hi        = ($urandom_range(9) == 0) ? 11'd1129 : LIM_W'($urandom_range(8));
      set_ranging(lo, hi, CFG_DATA_W'(cur_pings), $urandom_range(3) == 0);
      repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(40, 20)) begin
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
          end
        end else begin
          repeat (cur_pings) begin
            case ($urandom_range(9))
              0, 1, 2, 3, 4, 5: pulses.push_back($urandom_range(130, 1));
              6, 7, 8:          pulses.push_back(58 * $urandom_range(3, 1)
                                                 + $urandom_range(2) - 1);
              default:          pulses.push_back($urandom_range(240, 131));
            endcase
          end
          case ($urandom_range(19))
            0, 1, 2:                   style = ECHO_HELD;
            3, 4, 5, 6, 7, 8, 9:       style = ECHO_NOISY;
            default:                   style = ECHO_CLEAN;
          endcase
          run_measurement(style);
        end
        repeat ($urandom_range(2)) send_tick(1'b0, 1'($urandom_range(1)), 1'b0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
